// File: rtl/core/dhm_pkg.sv
package dhm_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned CntW      = $clog2(WORD_BITS);
  localparam int unsigned CfgIdxW   = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CfgIdxW-1:0]   cfg_idx_t;
  typedef logic [1:0]           err_t;

  localparam cfg_idx_t CFG_MODULUS   = 2'd0;
  localparam cfg_idx_t CFG_GENERATOR = 2'd1;
  localparam cfg_idx_t CFG_PRIV_EXP  = 2'd2;

  localparam err_t ERR_OK       = 2'd0;
  localparam err_t ERR_NO_KEY   = 2'd1;
  localparam err_t ERR_BAD_PARM = 2'd2;

  localparam word_t RESET_MODULUS   = word_t'(23);
  localparam word_t RESET_GENERATOR = word_t'(5);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_W,
    ST_ACC,
    ST_ACC_W,
    ST_SQR,
    ST_SQR_W
  } dhm_state_e;

endpackage

// File: rtl/core/diffie_hellman_modexp.sv
// Channel   Direction  Handshake              Payload
// request   in         start & !busy          func_i, peer_value_i
// result    out        done_o (one cycle)     key_value_o, error_code_o
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// Each product runs on one shift-add modular multiplier, one bit per cycle.
// A request reduces the base mod p, then takes one product per set bit of x and
// one square per bit of x below the top one; errors return in the cycle after start.
// busy is high for the whole job. Reset restores p = 23, g = 5, x = 0.
// The result strobe lasts one cycle and cannot be stalled.
module diffie_hellman_modexp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  dhm_pkg::cfg_idx_t   cfg_idx_i,
  input  dhm_pkg::word_t      cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  dhm_pkg::word_t      peer_value_i,
  output logic                done_o,
  output dhm_pkg::word_t      key_value_o,
  output dhm_pkg::err_t       error_code_o
);

  dhm_pkg::word_t     p_q, g_q, x_q;
  dhm_pkg::dhm_state_e state_q, state_d;
  dhm_pkg::word_t     acc_q, acc_d;
  dhm_pkg::word_t     base_q, base_d;
  dhm_pkg::word_t     exp_q, exp_d;
  logic               done_q, done_d;
  dhm_pkg::word_t     key_q, key_d;
  dhm_pkg::err_t      err_q, err_d;

  logic               mul_start;
  dhm_pkg::word_t     mul_a, mul_b;
  logic               mul_done;
  dhm_pkg::word_t     mul_res;
  dhm_pkg::err_t      chk_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= dhm_pkg::RESET_MODULUS;
      g_q <= dhm_pkg::RESET_GENERATOR;
      x_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dhm_pkg::CFG_MODULUS:   p_q <= cfg_data_i;
        dhm_pkg::CFG_GENERATOR: g_q <= cfg_data_i;
        dhm_pkg::CFG_PRIV_EXP:  x_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (p_q[dhm_pkg::WORD_BITS-1:1] == '0 || g_q[dhm_pkg::WORD_BITS-1:1] == '0 ||
        g_q >= p_q) begin
      chk_err = dhm_pkg::ERR_BAD_PARM;
    end else if (x_q == '0) begin
      chk_err = dhm_pkg::ERR_NO_KEY;
    end else begin
      chk_err = dhm_pkg::ERR_OK;
    end
  end

  dhm_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .m_i      (p_q),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    base_d    = base_q;
    exp_d     = exp_q;
    done_d    = 1'b0;
    key_d     = key_q;
    err_d     = err_q;
    mul_start = 1'b0;
    mul_a     = base_q;
    mul_b     = base_q;
    case (state_q)
      dhm_pkg::ST_IDLE: begin
        if (start) begin
          base_d = func_i ? peer_value_i : g_q;
          acc_d  = dhm_pkg::word_t'(1);
          exp_d  = x_q;
          if (chk_err != dhm_pkg::ERR_OK) begin
            done_d = 1'b1;
            key_d  = '0;
            err_d  = chk_err;
          end else begin
            state_d = dhm_pkg::ST_RED;
          end
        end
      end
      dhm_pkg::ST_RED: begin
        // base mod p as base * 1
        mul_start = 1'b1;
        mul_a     = base_q;
        mul_b     = dhm_pkg::word_t'(1);
        state_d   = dhm_pkg::ST_RED_W;
      end
      dhm_pkg::ST_RED_W: begin
        if (mul_done) begin
          base_d  = mul_res;
          state_d = exp_q[0] ? dhm_pkg::ST_ACC : dhm_pkg::ST_SQR;
        end
      end
      dhm_pkg::ST_ACC: begin
        mul_start = 1'b1;
        mul_a     = acc_q;
        mul_b     = base_q;
        state_d   = dhm_pkg::ST_ACC_W;
      end
      dhm_pkg::ST_ACC_W: begin
        if (mul_done) begin
          acc_d   = mul_res;
          state_d = dhm_pkg::ST_SQR;
        end
      end
      dhm_pkg::ST_SQR: begin
        // skip the square after the top exponent bit
        if (exp_q[dhm_pkg::WORD_BITS-1:1] == '0) begin
          done_d  = 1'b1;
          key_d   = acc_q;
          err_d   = dhm_pkg::ERR_OK;
          state_d = dhm_pkg::ST_IDLE;
        end else begin
          mul_start = 1'b1;
          state_d   = dhm_pkg::ST_SQR_W;
        end
      end
      dhm_pkg::ST_SQR_W: begin
        if (mul_done) begin
          base_d  = mul_res;
          exp_d   = {1'b0, exp_q[dhm_pkg::WORD_BITS-1:1]};
          state_d = exp_q[1] ? dhm_pkg::ST_ACC : dhm_pkg::ST_SQR;
        end
      end
      default: state_d = dhm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhm_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    key_q  <= key_d;
    err_q  <= err_d;
  end

  assign busy         = (state_q != dhm_pkg::ST_IDLE);
  assign done_o       = done_q;
  assign key_value_o  = key_q;
  assign error_code_o = err_q;

endmodule

// File: rtl/core/dhm_mulmod.sv
module dhm_mulmod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dhm_pkg::word_t   a_i,
  input  dhm_pkg::word_t   b_i,
  input  dhm_pkg::word_t   m_i,
  output logic             done_o,
  output dhm_pkg::word_t   result_o
);

  localparam int unsigned W = dhm_pkg::WORD_BITS;

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [dhm_pkg::CntW-1:0] cnt_q, cnt_d;
  dhm_pkg::word_t         r_q, r_d;
  dhm_pkg::word_t         a_q, a_d;
  dhm_pkg::word_t         b_q, b_d;
  dhm_pkg::word_t         m_q, m_d;

  logic [W:0]             dbl;
  dhm_pkg::word_t         dbl_red;
  logic [W:0]             sum;
  dhm_pkg::word_t         step;

  // one bit of a per cycle, MSB first: r = 2r + bit*b, kept below m
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : W'(dbl);
    sum     = {1'b0, dbl_red} + (a_q[W-1] ? {1'b0, b_q} : '0);
    step    = (sum >= {1'b0, m_q}) ? W'(sum - {1'b0, m_q}) : W'(sum);
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = dhm_pkg::CntW'(W - 1);
      r_d   = '0;
      a_d   = a_i;
      b_d   = b_i;
      m_d   = m_i;
    end else if (run_q) begin
      r_d   = step;
      a_d   = {a_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

endmodule
